// ===== design/text_console_glyph_renderer_macros.svh =====
// ----------------------------------------------------------------------------
// Text console glyph renderer assertion macros
// Shared property shorthands for the checker; all sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCGR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgr_pkg
// Types and fixed constants shared by the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int FONT_AW        = 12;
  localparam int FONT_DEPTH     = 4096;
  localparam int GLYPH_STRIDE_W = 4;   // glyphs sit 16 apart in the font store
  localparam int CHAR_W         = 8;
  localparam int COLOUR_W       = 8;
  localparam int PIX_COORD_W    = 10;
  localparam int PIXELS_W       = 64;
  localparam int CLR_ROW_W      = 6;
  localparam int OP_W           = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int IN_TDATA_W     = 32;
  localparam int OUT_TDATA_W    = 96;
  localparam int TAB_CELLS      = 4;

  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_FONT   = 2'd1;
  localparam logic [OP_W-1:0] OP_CURSOR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_FG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_BG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_FG = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_BG = 2'd3;

  localparam logic [COLOUR_W-1:0] RST_TEXT_FG   = 8'h22;
  localparam logic [COLOUR_W-1:0] RST_TEXT_BG   = 8'hff;
  localparam logic [COLOUR_W-1:0] RST_CURSOR_FG = 8'hff;
  localparam logic [COLOUR_W-1:0] RST_CURSOR_BG = 8'h22;

  typedef struct packed {
    logic                 we;
    logic [FONT_AW-1:0]   addr;
    logic [CHAR_W-1:0]    data;
  } font_wr_t;

  typedef struct packed {
    logic                 re;
    logic [FONT_AW-1:0]   addr;
  } font_rd_t;

  // Everything a glyph line needs besides the font byte itself.
  typedef struct packed {
    logic [PIX_COORD_W-1:0] pixel_row;
    logic [PIX_COORD_W-1:0] pixel_column;
    logic [COLOUR_W-1:0]    fg;
    logic [COLOUR_W-1:0]    bg;
    logic                   scroll_up;
    logic                   clear_row;
    logic [CLR_ROW_W-1:0]   clear_text_row;
    logic                   last;
  } line_meta_t;

  typedef struct packed {
    logic [PIX_COORD_W-1:0] pixel_row;
    logic [PIX_COORD_W-1:0] pixel_column;
    logic [PIXELS_W-1:0]    pixels;
    logic                   scroll_up;
    logic                   clear_row;
    logic [CLR_ROW_W-1:0]   clear_text_row;
    logic                   last;
  } out_beat_t;

endpackage

// ===== design/text_console_glyph_renderer.sv =====
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// 8-pixel-wide bitmap-font text console writing eight-pixel framebuffer beats.
// ----------------------------------------------------------------------------
// One operation is taken per input beat. A font load writes one byte of the
// font RAM. A put character or draw cursor paints one to four glyphs (tab up
// to four, backspace two, everything else one); each glyph is GLYPH_LINES
// font RAM reads on the single read port, issued back to back while the
// output does not stall, giving one output beat per line. A new operation is
// taken only after the last read of the one before has been issued. The font
// RAM has no reset; glyphs must be loaded before they are drawn. Scrolling and
// row clearing are only flagged on the final beat of an operation.
module text_console_glyph_renderer
  import tcgr_pkg::*;
#(
  parameter int TEXT_COLUMNS = 128,
  parameter int TEXT_ROWS    = 48,
  parameter int GLYPH_LINES  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // char_code[7:0], font_address[19:8], font_data[27:20], zero[31:28]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [OP_W-1:0]        in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pixel_row[9:0], pixel_column[19:10], pixels[83:20], scroll_up[84],
  // clear_row[85], clear_text_row[91:86], zero[95:92]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COLOUR_W-1:0]    cfg_wdata
);

  font_wr_t          font_wr;
  font_rd_t          font_rd;
  logic [CHAR_W-1:0] font_rdata;
  line_meta_t        issue_meta;
  logic              s1_free;
  out_beat_t         out_beat;

  tcgr_seq #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .GLYPH_LINES  (GLYPH_LINES)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (in_tuser),
    .in_char      (in_tdata[7:0]),
    .in_font_addr (in_tdata[19:8]),
    .in_font_data (in_tdata[27:20]),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .s1_free      (s1_free),
    .font_wr      (font_wr),
    .font_rd      (font_rd),
    .issue_meta   (issue_meta)
  );

  tcgr_font_mem u_font_mem (
    .clk   (clk),
    .wr    (font_wr),
    .rd    (font_rd),
    .rdata (font_rdata)
  );

  tcgr_pixel_out u_pixel_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (font_rd.re),
    .issue_meta (issue_meta),
    .rdata      (font_rdata),
    .s1_free    (s1_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_beat   (out_beat)
  );

  assign out_tdata = {4'b0000, out_beat.clear_text_row, out_beat.clear_row,
                      out_beat.scroll_up, out_beat.pixels,
                      out_beat.pixel_column, out_beat.pixel_row};
  assign out_tlast = out_beat.last;

endmodule

// ===== design/tcgr_font_mem.sv =====
// ----------------------------------------------------------------------------
// tcgr_font_mem
// Font store: 4096 x 8 synchronous RAM, one write and one read port; the read
// data is registered and holds while no read is enabled.
// ----------------------------------------------------------------------------
module tcgr_font_mem
  import tcgr_pkg::*;
(
  input  logic              clk,
  input  font_wr_t          wr,
  input  font_rd_t          rd,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [FONT_DEPTH];
  logic [CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata_r <= mem[rd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tcgr_seq.sv =====
// ----------------------------------------------------------------------------
// tcgr_seq
// Command sequencer: colour registers, text cursor, font writes and the
// line-by-line read schedule for each glyph an operation paints.
// ----------------------------------------------------------------------------
module tcgr_seq
  import tcgr_pkg::*;
#(
  parameter int TEXT_COLUMNS = 128,
  parameter int TEXT_ROWS    = 48,
  parameter int GLYPH_LINES  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_op,
  input  logic [CHAR_W-1:0]    in_char,
  input  logic [FONT_AW-1:0]   in_font_addr,
  input  logic [CHAR_W-1:0]    in_font_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOUR_W-1:0]  cfg_wdata,
  input  logic                 s1_free,
  output font_wr_t             font_wr,
  output font_rd_t             font_rd,
  output line_meta_t           issue_meta
);

  localparam int COL_W   = $clog2(TEXT_COLUMNS);
  localparam int COL_SW  = COL_W + 1;
  localparam int ROW_W   = $clog2(TEXT_ROWS);
  localparam int ROW_SW  = ROW_W + 1;
  localparam int LINE_W  = $clog2(GLYPH_LINES);
  localparam int PROD_W  = ROW_W + 5;

  localparam logic [COL_SW-1:0] COLS_V     = COL_SW'(TEXT_COLUMNS);
  localparam logic [COL_SW-1:0] TAB_V      = COL_SW'(TAB_CELLS);
  localparam logic [ROW_SW-1:0] ROW_LAST_S = ROW_SW'(TEXT_ROWS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(TEXT_ROWS - 1);
  localparam logic [LINE_W-1:0] LINE_LAST  = LINE_W'(GLYPH_LINES - 1);
  localparam logic [1:0]        TAB_PASS_LAST = 2'(TAB_CELLS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                  state_r;
  logic [COL_W-1:0]      cur_col_r;
  logic [ROW_W-1:0]      cur_row_r;
  logic [COLOUR_W-1:0]   text_fg_r, text_bg_r, cursor_fg_r, cursor_bg_r;

  logic [1:0]            pass_r, pass_last_r;
  logic [LINE_W-1:0]     line_r;
  logic                  is_bs_r;
  logic [CHAR_W-1:0]     char_r;
  logic [COL_W-1:0]      base_col_r, left_col_r;
  logic [COLOUR_W-1:0]   fg_r, bg_r;
  logic [PIX_COORD_W-1:0] row_base_r;
  logic                  scroll_r, clear_r;
  logic [CLR_ROW_W-1:0]  clear_text_row_r;

  logic                  accept, start, is_put, issue, last_line, last_pass;
  logic                  is_nl, is_bs, is_tab, wrap, row_inc, scroll_nxt;
  logic [COL_W-1:0]      left_col, cur_col_nxt, cell_col;
  logic [COL_SW-1:0]     col_sum, room;
  logic [ROW_SW-1:0]     row_sum;
  logic [ROW_W-1:0]      cur_row_nxt;
  logic [1:0]            tab_last, pass_last_nxt;
  logic [CHAR_W-1:0]     char_nxt, pass_char;
  logic [PROD_W-1:0]     row_prod;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_put    = (in_op == OP_PUT);
  assign start     = accept && (is_put || (in_op == OP_CURSOR));
  assign issue     = (state_r == ST_RUN) && s1_free;
  assign last_line = (line_r == LINE_LAST);
  assign last_pass = (pass_r == pass_last_r);

  assign is_nl  = is_put && (in_char == CH_NEWLINE);
  assign is_bs  = is_put && (in_char == CH_BACKSPACE);
  assign is_tab = is_put && (in_char == CH_TAB);

  // Cursor move and the plan of glyph passes for the accepted operation.
  always_comb begin
    left_col = (cur_col_r == '0) ? '0 : cur_col_r - 1'b1;
    room     = COLS_V - {1'b0, cur_col_r};
    tab_last = (room >= TAB_V) ? TAB_PASS_LAST : 2'(room - 1'b1);

    if (is_nl) begin
      col_sum = '0;
    end else if (is_bs) begin
      col_sum = {1'b0, left_col};
    end else if (is_tab) begin
      col_sum = {1'b0, cur_col_r} + TAB_V;
    end else begin
      col_sum = {1'b0, cur_col_r} + 1'b1;
    end

    wrap        = (col_sum >= COLS_V);
    row_inc     = is_nl || wrap;
    row_sum     = {1'b0, cur_row_r} + ROW_SW'(row_inc);
    scroll_nxt  = (row_sum > ROW_LAST_S);
    cur_row_nxt = scroll_nxt ? ROW_LAST : ROW_W'(row_sum);
    cur_col_nxt = wrap ? '0 : COL_W'(col_sum);

    if (is_bs) begin
      pass_last_nxt = 2'd1;
    end else if (is_tab) begin
      pass_last_nxt = tab_last;
    end else begin
      pass_last_nxt = 2'd0;
    end

    char_nxt = (is_put && !is_nl && !is_bs && !is_tab) ? in_char : CH_SPACE;
    row_prod = PROD_W'(cur_row_r) * PROD_W'(GLYPH_LINES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      text_fg_r   <= RST_TEXT_FG;
      text_bg_r   <= RST_TEXT_BG;
      cursor_fg_r <= RST_CURSOR_FG;
      cursor_bg_r <= RST_CURSOR_BG;
      pass_r      <= '0;
      line_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TEXT_FG:   text_fg_r   <= cfg_wdata;
          REG_TEXT_BG:   text_bg_r   <= cfg_wdata;
          REG_CURSOR_FG: cursor_fg_r <= cfg_wdata;
          REG_CURSOR_BG: cursor_bg_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (start) begin
        state_r <= ST_RUN;
        pass_r  <= '0;
        line_r  <= '0;
        if (is_put) begin
          cur_col_r <= cur_col_nxt;
          cur_row_r <= cur_row_nxt;
        end
      end

      if (issue) begin
        if (last_line) begin
          line_r <= '0;
          if (last_pass) begin
            state_r <= ST_IDLE;
          end else begin
            pass_r <= pass_r + 1'b1;
          end
        end else begin
          line_r <= line_r + 1'b1;
        end
      end
    end
  end

  // Plan registers; painting uses the cursor as it stood before the move.
  always_ff @(posedge clk) begin
    if (start) begin
      pass_last_r <= is_put ? pass_last_nxt : 2'd0;
      is_bs_r     <= is_bs;
      char_r      <= char_nxt;
      base_col_r  <= cur_col_r;
      left_col_r  <= left_col;
      fg_r        <= is_put ? text_fg_r : cursor_fg_r;
      bg_r        <= is_put ? text_bg_r : cursor_bg_r;
      row_base_r  <= PIX_COORD_W'(row_prod);
      scroll_r    <= is_put && scroll_nxt;
      clear_r     <= is_nl;
      clear_text_row_r <= is_nl ? CLR_ROW_W'(cur_row_nxt) : '0;
    end
  end

  // Second backspace pass blanks the cell to the left with glyph zero.
  always_comb begin
    if (is_bs_r && (pass_r == 2'd1)) begin
      cell_col  = left_col_r;
      pass_char = CH_BLANK;
    end else begin
      cell_col  = base_col_r + COL_W'(pass_r);
      pass_char = char_r;
    end

    issue_meta.pixel_row      = row_base_r + PIX_COORD_W'(line_r);
    issue_meta.pixel_column   = PIX_COORD_W'({cell_col, 3'b000});
    issue_meta.fg             = fg_r;
    issue_meta.bg             = bg_r;
    issue_meta.last           = last_line && last_pass;
    issue_meta.scroll_up      = last_line && last_pass && scroll_r;
    issue_meta.clear_row      = last_line && last_pass && clear_r;
    issue_meta.clear_text_row = (last_line && last_pass) ? clear_text_row_r : '0;

    font_rd.re   = issue;
    font_rd.addr = {pass_char, GLYPH_STRIDE_W'(line_r)};

    font_wr.we   = accept && (in_op == OP_FONT);
    font_wr.addr = in_font_addr;
    font_wr.data = in_font_data;
  end

endmodule

// ===== design/tcgr_pixel_out.sv =====
// ----------------------------------------------------------------------------
// tcgr_pixel_out
// Read-data stage and output register: pairs each font byte with its line
// information, expands it to eight palette bytes and holds the beat.
// ----------------------------------------------------------------------------
module tcgr_pixel_out
  import tcgr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              issue,
  input  line_meta_t        issue_meta,
  input  logic [CHAR_W-1:0] rdata,
  output logic              s1_free,
  output logic              out_valid,
  input  logic              out_ready,
  output out_beat_t         out_beat
);

  logic       s1_valid_r;
  line_meta_t s1_meta_r;
  logic       out_valid_r;
  out_beat_t  out_r;
  logic       out_free;
  logic [PIXELS_W-1:0] pixels;

  assign out_free = !out_valid_r || out_ready;
  // A new read may only land when the read stage is empty or empties in the same cycle.
  assign s1_free  = !s1_valid_r || out_free;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pixels[8*i +: 8] = rdata[7-i] ? s1_meta_r.fg : s1_meta_r.bg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (issue) begin
        s1_valid_r <= 1'b1;
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_meta_r <= issue_meta;
    end
    if (out_free && s1_valid_r) begin
      out_r.pixel_row      <= s1_meta_r.pixel_row;
      out_r.pixel_column   <= s1_meta_r.pixel_column;
      out_r.pixels         <= pixels;
      out_r.scroll_up      <= s1_meta_r.scroll_up;
      out_r.clear_row      <= s1_meta_r.clear_row;
      out_r.clear_text_row <= s1_meta_r.clear_text_row;
      out_r.last           <= s1_meta_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule

// ===== design/tcgr_checker.sv =====
// ----------------------------------------------------------------------------
// tcgr_checker
// Port-level checks on the renderer's output beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_glyph_renderer_macros.svh"

module tcgr_checker
  import tcgr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // A stalled beat must hold.
  `TCGR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output beat changed while stalled")
  // Scroll and clear flags only ride on the final beat of an operation.
  `TCGR_ASSERT_SAME(a_flags_last, out_tvalid && !out_tlast, out_tdata[91:84] == 8'd0, "scroll or clear flag on a non-final beat")
  `TCGR_ASSERT_SAME(a_clear_row_zero, out_tvalid && !out_tdata[85], out_tdata[91:86] == 6'd0, "clear_text_row set without clear_row")
  `TCGR_ASSERT_SAME(a_col_aligned, out_tvalid, out_tdata[12:10] == 3'd0, "pixel_column not a multiple of eight")

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
